// File: hdl/wsd_pkg.sv
`timescale 1ns / 1ps
// wsd_pkg: types and constants shared by the frame deframer modules.
// No dependencies.
package wsd_pkg;

  localparam logic [7:0] OP_TEXT  = 8'd129;
  localparam logic [7:0] OP_CLOSE = 8'd136;

  localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [6:0] LEN_EXT64     = 7'd127;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } wsd_result_t;

endpackage

// File: hdl/wsd_rx_if.sv
`timescale 1ns / 1ps
// wsd_rx_if: valid/ready channel carrying received frame bytes.
// No dependencies.
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/wsd_res_if.sv
`timescale 1ns / 1ps
// wsd_res_if: valid/ready channel carrying deframer results.
// No dependencies.
interface wsd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

// File: hdl/wsd_parser.sv
`timescale 1ns / 1ps
// wsd_parser: frame header/mask/payload state and the per-byte decode step.
// Depends on wsd_pkg.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output wsd_result_t result
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_LENHI  = 3'd2;
  localparam logic [2:0] PH_LENLO  = 3'd3;
  localparam logic [2:0] PH_MASK   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_CLOSED = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [7:0]  opcode_byte, opcode_byte_next;
  logic [15:0] remaining, remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_count, mask_count_next;
  logic [1:0]  byte_index, byte_index_next;

  logic [6:0]  code;
  logic [7:0]  key;
  logic [15:0] rem_dec;

  assign code    = rx_byte[6:0];
  assign rem_dec = remaining - 16'd1;

  always_comb begin
    case (byte_index)
      2'd0:    key = mask_key[31:24];
      2'd1:    key = mask_key[23:16];
      2'd2:    key = mask_key[15:8];
      default: key = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next       = phase;
    opcode_byte_next = opcode_byte;
    remaining_next   = remaining;
    mask_key_next    = mask_key;
    mask_count_next  = mask_count;
    byte_index_next  = byte_index;
    result           = '0;
    case (phase)
      PH_HDR0: begin
        opcode_byte_next = rx_byte;
        phase_next       = PH_HDR1;
      end
      PH_HDR1: begin
        if (opcode_byte == OP_CLOSE) begin
          phase_next  = PH_CLOSED;
          result.valid = 1'b1;
          result.kind  = KIND_CLOSE;
          result.last  = 1'b1;
        end else if (opcode_byte != OP_TEXT || code == LEN_EXT64) begin
          phase_next   = PH_HDR0;
          result.valid = 1'b1;
          result.kind  = KIND_BAD;
          result.last  = 1'b1;
        end else begin
          mask_count_next = 2'd0;
          if (code <= LEN_SHORT_MAX) begin
            remaining_next = {9'd0, code};
            phase_next     = PH_MASK;
          end else begin
            remaining_next = 16'd0;
            phase_next     = PH_LENHI;
          end
        end
      end
      PH_LENHI: begin
        remaining_next = {rx_byte, 8'd0};
        phase_next     = PH_LENLO;
      end
      PH_LENLO: begin
        remaining_next = {remaining[15:8], rx_byte};
        phase_next     = PH_MASK;
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (mask_count != 2'd3) begin
          mask_count_next = mask_count + 2'd1;
        end else begin
          mask_count_next = 2'd0;
          byte_index_next = 2'd0;
          if (remaining == 16'd0) begin
            phase_next   = PH_HDR0;
            result.valid = 1'b1;
            result.kind  = KIND_EMPTY;
            result.last  = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        byte_index_next = byte_index + 2'd1;
        remaining_next  = rem_dec;
        result.valid    = 1'b1;
        result.out_byte = rx_byte ^ key;
        result.kind     = KIND_DATA;
        if (rem_dec == 16'd0) begin
          phase_next  = PH_HDR0;
          result.last = 1'b1;
        end
      end
      default: begin
        // closed, or unused code: drop
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      mask_count <= 2'd0;
      byte_index <= 2'd0;
    end else if (step) begin
      phase      <= phase_next;
      mask_count <= mask_count_next;
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      opcode_byte <= opcode_byte_next;
      remaining   <= remaining_next;
      mask_key    <= mask_key_next;
    end
  end

endmodule

// File: hdl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// websocket_frame_deframer: input register, then parser, then result register.
// Throughput one byte per cycle; bytes keep streaming while a result waits, stalling
// only when a byte yields a result while the result register is held.
// Synchronous active-high reset returns the parser to the first header byte
// and empties both registers. Depends on wsd_pkg, wsd_rx_if, wsd_res_if, wsd_parser.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  wsd_rx_if.sink    rx,
  wsd_res_if.source res
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;
  wsd_result_t step_res;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_last;

  assign advance  = in_valid && (!step_res.valid || !out_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  wsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_byte <= step_res.out_byte;
      out_kind <= step_res.kind;
      out_last <= step_res.last;
    end
  end

  assign res.valid    = out_valid;
  assign res.out_byte = out_byte;
  assign res.kind     = out_kind;
  assign res.last     = out_last;

endmodule

// File: hdl/wsd_checker.sv
`timescale 1ns / 1ps
// wsd_checker: port-level assertions for the deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer.
module wsd_checker
  import wsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_last
);

  a_ctrl_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_DATA |-> out_last)
    else $error("non-payload result without last");

  a_ctrl_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_DATA |-> out_byte == 8'd0)
    else $error("non-payload result with non-zero byte");

  a_close_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_kind == KIND_CLOSE |=> !out_valid)
    else $error("result after close frame");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_byte  (res.out_byte),
  .out_kind  (res.kind),
  .out_last  (res.last)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for websocket_frame_deframer; directed frames around random frame
// streams under varied idling and stalls, checked against an in-bench deframer predictor.
// Depends on wsd_pkg, wsd_rx_if, wsd_res_if and websocket_frame_deframer.
module tb;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int N_OPEN_ROWS  = 26;
  localparam int N_ROWS       = 30;
  localparam int PHASE_BYTES  = 425;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_LENHI, PH_LENLO, PH_MASK, PH_DATA, PH_CLOSED
  } parse_ph_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } ws_res_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       typed;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } dir_row_t;

  logic clk;
  logic rst;

  wsd_rx_if  rx ();
  wsd_res_if res ();

  websocket_frame_deframer dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res)
  );

  // predictor state
  parse_ph_t   ph;
  logic [7:0]  frame_op;
  logic [15:0] bytes_left;
  logic [31:0] key_word;
  logic [1:0]  key_cnt;
  logic [1:0]  pay_idx;

  ws_res_t    pending_res [$];
  logic [7:0] frame_buf [$];
  dir_row_t   dir_rows [N_ROWS];

  logic    row_typed;
  ws_res_t row_res;
  int      idle_pct;
  int      stall_pct;
  int      hold_cycles;
  int      errors;
  int      n_bytes;
  int      n_random;
  int      n_kind [4];
  longint  cycle_cnt;

  function automatic bit deframe_step(input logic [7:0] b, output ws_res_t r);
    logic [6:0] code;
    logic [7:0] kb;
    bit         hit;
    r    = '0;
    hit  = 1'b0;
    code = b[6:0];
    case (ph)
      PH_HDR0: begin
        frame_op = b;
        ph = PH_HDR1;
      end
      PH_HDR1: begin
        if (frame_op == OP_CLOSE) begin
          ph = PH_CLOSED;
          r.kind = KIND_CLOSE;
          r.last = 1'b1;
          hit = 1'b1;
        end else if (frame_op != OP_TEXT || code == LEN_EXT64) begin
          ph = PH_HDR0;
          r.kind = KIND_BAD;
          r.last = 1'b1;
          hit = 1'b1;
        end else begin
          key_cnt  = 2'd0;
          key_word = '0;
          if (code <= LEN_SHORT_MAX) begin
            bytes_left = {9'd0, code};
            ph = PH_MASK;
          end else begin
            bytes_left = '0;
            ph = PH_LENHI;
          end
        end
      end
      PH_LENHI: begin
        bytes_left = {b, 8'h00};
        ph = PH_LENLO;
      end
      PH_LENLO: begin
        bytes_left[7:0] = b;
        ph = PH_MASK;
      end
      PH_MASK: begin
        key_word = {key_word[23:0], b};
        if (key_cnt != 2'd3) begin
          key_cnt = key_cnt + 2'd1;
        end else begin
          key_cnt = 2'd0;
          pay_idx = 2'd0;
          if (bytes_left == 16'd0) begin
            ph = PH_HDR0;
            r.kind = KIND_EMPTY;
            r.last = 1'b1;
            hit = 1'b1;
          end else begin
            ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        kb = key_word[31 - 8 * pay_idx -: 8];
        pay_idx = pay_idx + 2'd1;
        bytes_left = bytes_left - 16'd1;
        r.out_byte = b ^ kb;
        r.kind = KIND_DATA;
        r.last = (bytes_left == 16'd0);
        if (bytes_left == 16'd0) ph = PH_HDR0;
        hit = 1'b1;
      end
      default: ;
    endcase
    return hit;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      rx.valid <= 1'b0;
      @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    @(negedge clk);
  endtask

  // keeps random streams clear of close frames and of huge extended lengths
  task automatic send_guarded(input logic [7:0] b, input bit long_ok);
    logic [7:0] g;
    g = b;
    if (ph == PH_HDR0 && g == OP_CLOSE) g = g ^ 8'h01;
    if (ph == PH_LENHI && !long_ok) g = g & 8'h01;
    send_byte(g);
    n_random++;
  endtask

  task automatic run_row(input int i);
    row_typed = dir_rows[i].typed;
    row_res   = {dir_rows[i].out_byte, dir_rows[i].kind, dir_rows[i].last};
    send_byte(dir_rows[i].rx_byte);
    row_typed = 1'b0;
  endtask

  task automatic resync();
    while (ph != PH_HDR0) send_guarded(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic send_text_frame(input logic [15:0] len, input bit long_ok);
    logic mb;
    mb = 1'($urandom_range(1));
    send_guarded(OP_TEXT, long_ok);
    send_guarded({mb, LEN_EXT16}, long_ok);
    send_guarded(len[15:8], long_ok);
    send_guarded(len[7:0], long_ok);
    repeat (4) send_guarded(8'($urandom_range(255)), long_ok);
    repeat (int'(len)) send_guarded(8'($urandom_range(255)), long_ok);
  endtask

  task automatic random_frame();
    int         r;
    int         sel;
    int         len;
    int         cut;
    bit         ext;
    logic       mb;
    logic [7:0] op;
    frame_buf.delete();
    r  = $urandom_range(99);
    mb = 1'($urandom_range(1));
    if (r < 8) begin
      do op = 8'($urandom_range(255)); while (op == OP_TEXT || op == OP_CLOSE);
      frame_buf.push_back(op);
      frame_buf.push_back(8'($urandom_range(255)));
    end else if (r < 13) begin
      frame_buf.push_back(OP_TEXT);
      frame_buf.push_back({mb, LEN_EXT64});
    end else begin
      sel = $urandom_range(99);
      ext = 1'b0;
      if (sel < 10) begin
        len = 0;
        ext = 1'($urandom_range(1));
      end else if (sel < 15) begin
        len = int'(LEN_SHORT_MAX);
      end else if (sel < 27) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(20);
        ext = 1'b1;
      end else begin
        len = $urandom_range(1, 16);
      end
      frame_buf.push_back(OP_TEXT);
      if (ext) begin
        frame_buf.push_back({mb, LEN_EXT16});
        frame_buf.push_back(len[15:8]);
        frame_buf.push_back(len[7:0]);
      end else begin
        frame_buf.push_back({mb, len[6:0]});
      end
      repeat (4 + len) frame_buf.push_back(8'($urandom_range(255)));
      // broken frame: cut short, so the next header lands mid-frame
      if (r >= 95) begin
        cut = $urandom_range(1, frame_buf.size() - 1);
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
    end
    foreach (frame_buf[i]) send_guarded(frame_buf[i], 1'b0);
  endtask

  task automatic run_phase(input int s_idle, input int r_stall);
    int start;
    idle_pct  = s_idle;
    stall_pct = r_stall;
    start     = n_random;
    while (n_random - start < PHASE_BYTES) random_frame();
  endtask

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_res.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      res.ready <= 1'b0;
      hold_cycles--;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    ws_res_t got;
    ws_res_t want;
    ws_res_t pred;
    bit      hit;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got = {res.out_byte, res.kind, res.last};
        if (pending_res.size() == 0) begin
          $error("unexpected result: out_byte %02h kind %0d last %0b",
                 got.out_byte, got.kind, got.last);
          errors++;
        end else begin
          want = pending_res.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            errors++;
          end
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
          end
        end
        n_kind[got.kind]++;
      end
      if (rx.valid && rx.ready) begin
        n_bytes++;
        hit = deframe_step(rx.rx_byte, pred);
        if (row_typed) pending_res.push_back(row_res);
        else if (hit) pending_res.push_back(pred);
      end
    end
  end

  initial begin
    rst         = 1'b1;
    rx.valid    = 1'b0;
    rx.rx_byte  = 8'h00;
    res.ready   = 1'b0;
    ph          = PH_HDR0;
    frame_op    = '0;
    bytes_left  = '0;
    key_word    = '0;
    key_cnt     = '0;
    pay_idx     = '0;
    row_typed   = 1'b0;
    row_res     = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    errors      = 0;
    n_bytes     = 0;
    n_random    = 0;
    cycle_cnt   = 0;
    n_kind      = '{0, 0, 0, 0};

    dir_rows = '{
      // unknown opcode
      '{8'hFF, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b1, 8'h00, KIND_BAD, 1'b1},
      // 64-bit length code
      '{OP_TEXT, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{{1'b1, LEN_EXT64}, 1'b1, 8'h00, KIND_BAD, 1'b1},
      // empty message, short length
      '{OP_TEXT, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h80, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b1, 8'h00, KIND_EMPTY, 1'b1},
      // empty message, extended length of zero
      '{OP_TEXT, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{{1'b0, LEN_EXT16}, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'hFF, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'hFF, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'hFF, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'hFF, 1'b1, 8'h00, KIND_EMPTY, 1'b1},
      // two payload bytes at the extremes
      '{OP_TEXT, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h82, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'hFF, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'hA5, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h5A, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b1, 8'hFF, KIND_DATA, 1'b0},
      '{8'hFF, 1'b1, 8'hFF, KIND_DATA, 1'b1},
      // close, then bytes that must be dropped
      '{OP_CLOSE, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h00, 1'b1, 8'h00, KIND_CLOSE, 1'b1},
      '{OP_TEXT, 1'b0, 8'h00, KIND_DATA, 1'b0},
      '{8'h81, 1'b0, 8'h00, KIND_DATA, 1'b0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_OPEN_ROWS; i++) run_row(i);

    run_phase(0, 0);
    resync();

    // long receiver hold while bytes keep coming
    rx.valid <= 1'b0;
    @(posedge clk);
    hold_cycles = 400;
    @(negedge clk);
    send_text_frame(16'd150, 1'b0);

    run_phase(69, 0);
    run_phase(0, 69);
    run_phase(24, 24);

    idle_pct = 0;
    resync();
    for (int i = N_OPEN_ROWS; i < N_ROWS; i++) run_row(i);

    rx.valid <= 1'b0;
    stall_pct = 0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d byte transactions, %0d of them in random frame streams",
             n_bytes, n_random);
    $display("Results: %0d payload, %0d empty, %0d close, %0d bad header",
             n_kind[KIND_DATA], n_kind[KIND_EMPTY], n_kind[KIND_CLOSE], n_kind[KIND_BAD]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
